@@ src/tvo_pkg.sv @@
// Package for the triangle/voxel overlap test.
// Register indexes, field widths and reset values; no dependencies.
`default_nettype none
package tvo_pkg;
  localparam int COORD_W = 32;
  localparam int SIZE_W  = 31;
  localparam int TOL_W   = 16;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [CFG_IW-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SIZE_X   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SIZE_Y   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_SIZE_Z   = 3'd5;
  localparam logic [CFG_IW-1:0] REG_TOL      = 3'd6;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 31'd65536;
endpackage
`default_nettype wire

@@ src/triangle_voxel_overlap_test.sv @@
// Triangle / voxel-box overlap, separating-axis test on 13 axes.
// Pipeline: capture, then 11 further pipe stages, then the queue write.
// Throughput: one word per cycle while the credit count allows;
// the 4-stage chunked multipliers set the depth.
// A 16-entry result queue with credit count keeps input open while results wait.
// Reset (rst, sync, active high) clears valids and queue; config goes to reset values.
`default_nettype none
module triangle_voxel_overlap_test #(
  parameter int INDEX_BITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tvo_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [tvo_pkg::CFG_DW-1:0]    cfg_data,
  // input words
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [31:0]            vertex_a_x,
  input  wire logic signed [31:0]            vertex_a_y,
  input  wire logic signed [31:0]            vertex_a_z,
  input  wire logic signed [31:0]            vertex_b_x,
  input  wire logic signed [31:0]            vertex_b_y,
  input  wire logic signed [31:0]            vertex_b_z,
  input  wire logic signed [31:0]            vertex_c_x,
  input  wire logic signed [31:0]            vertex_c_y,
  input  wire logic signed [31:0]            vertex_c_z,
  input  wire logic [INDEX_BITS-1:0]         cell_ix,
  input  wire logic [INDEX_BITS-1:0]         cell_iy,
  input  wire logic [INDEX_BITS-1:0]         cell_iz,
  // result words
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               overlaps
);
  import tvo_pkg::*;

  // widths: c2 = doubled box center, rel = doubled vertex offset
  localparam int C2W = INDEX_BITS + 34;
  localparam int RW  = INDEX_BITS + 35;
  localparam int EW  = 33;              // edge component
  localparam int AEW = 34;              // edge magnitude
  localparam int NW  = 67;              // normal component
  localparam int ANW = 68;              // normal magnitude
  localparam int FW  = RW + 1;          // face axis compare
  localparam int EDW = RW + 35;         // edge axis compare
  localparam int NDW = RW + 69;         // normal axis compare
  localparam int PIPE = 12;
  localparam int QD   = 16;
  localparam int QAW  = 4;

  // ---------------- config registers ----------------
  logic signed [COORD_W-1:0] org [3];
  logic [SIZE_W-1:0]         csz [3];
  logic [TOL_W-1:0]          tol;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0; org[1] <= '0; org[2] <= '0;
      csz[0] <= SIZE_RESET; csz[1] <= SIZE_RESET; csz[2] <= SIZE_RESET;
      tol    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X: org[0] <= cfg_data;
        REG_ORIGIN_Y: org[1] <= cfg_data;
        REG_ORIGIN_Z: org[2] <= cfg_data;
        REG_SIZE_X:   csz[0] <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y:   csz[1] <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z:   csz[2] <= cfg_data[SIZE_W-1:0];
        REG_TOL:      tol    <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] sz [3];
  for (genvar c = 0; c < 3; c++) begin : g_sz
    assign sz[c] = $signed({1'b0, csz[c]});
  end

  // ---------------- valid chain and credit ----------------
  logic           acc_in, acc_out;
  logic [PIPE-1:0] vl;
  logic [QAW:0]   occ;

  assign acc_in  = in_valid & in_ready;
  assign acc_out = out_valid & out_ready;
  // credit: words in flight plus words queued never exceed queue depth
  assign in_ready = (occ < (QAW+1)'(QD));

  always_ff @(posedge clk) begin
    if (rst) begin
      vl  <= '0;
      occ <= '0;
    end else begin
      vl  <= {vl[PIPE-2:0], acc_in};
      occ <= occ + (QAW+1)'(acc_in) - (QAW+1)'(acc_out);
    end
  end

  // ---------------- stage 1: capture ----------------
  logic signed [31:0]     v1 [3][3];
  logic [INDEX_BITS-1:0]  ix1 [3];

  always_ff @(posedge clk) begin
    v1[0][0] <= vertex_a_x; v1[0][1] <= vertex_a_y; v1[0][2] <= vertex_a_z;
    v1[1][0] <= vertex_b_x; v1[1][1] <= vertex_b_y; v1[1][2] <= vertex_b_z;
    v1[2][0] <= vertex_c_x; v1[2][1] <= vertex_c_y; v1[2][2] <= vertex_c_z;
    ix1[0]   <= cell_ix;    ix1[1]   <= cell_iy;    ix1[2]   <= cell_iz;
  end

  // ---------------- stage 2: edges, box center ----------------
  logic signed [EW-1:0]  e2  [3][3];   // e2[k] = v[k+1] - v[k]
  logic signed [EW-1:0]  ca2 [3];      // c - a, for the normal
  logic signed [C2W-1:0] c2  [3];
  logic signed [31:0]    v2  [3][3];

  for (genvar c = 0; c < 3; c++) begin : g_s2
    logic [INDEX_BITS:0]    odd;
    logic [INDEX_BITS+31:0] span;
    assign odd  = {ix1[c], 1'b1};
    assign span = odd * csz[c];
    always_ff @(posedge clk) begin
      c2[c]  <= (C2W'(org[c]) <<< 1) + $signed(C2W'(span));
      ca2[c] <= EW'(v1[2][c]) - EW'(v1[0][c]);
    end
    for (genvar k = 0; k < 3; k++) begin : g_k
      always_ff @(posedge clk) begin
        e2[k][c] <= EW'(v1[(k+1)%3][c]) - EW'(v1[k][c]);
        v2[k][c] <= v1[k][c];
      end
    end
  end

  // ---------------- stage 3: offsets, normal partial products ----------------
  logic signed [RW-1:0]   rel3 [3][3];
  logic signed [EW-1:0]   e3   [3][3];
  logic signed [2*EW-1:0] np3  [3][2];

  for (genvar c = 0; c < 3; c++) begin : g_s3
    always_ff @(posedge clk) begin
      np3[c][0] <= e2[0][(c+1)%3] * ca2[(c+2)%3];
      np3[c][1] <= e2[0][(c+2)%3] * ca2[(c+1)%3];
    end
    for (genvar k = 0; k < 3; k++) begin : g_k
      always_ff @(posedge clk) begin
        rel3[k][c] <= (RW'(v2[k][c]) <<< 1) - RW'(c2[c]);
        e3[k][c]   <= e2[k][c];
      end
    end
  end

  // ---------------- stage 4: normal, magnitudes ----------------
  logic signed [RW-1:0]  rel4 [3][3];
  logic signed [EW-1:0]  e4   [3][3];
  logic signed [AEW-1:0] ae4  [3][3];
  logic signed [NW-1:0]  n4   [3];
  logic signed [ANW-1:0] an4  [3];
  logic signed [NW-1:0]  nd3  [3];

  for (genvar c = 0; c < 3; c++) begin : g_s4
    assign nd3[c] = NW'(np3[c][0]) - NW'(np3[c][1]);
    always_ff @(posedge clk) begin
      n4[c]  <= nd3[c];
      an4[c] <= nd3[c][NW-1] ? -ANW'(nd3[c]) : ANW'(nd3[c]);
    end
    for (genvar k = 0; k < 3; k++) begin : g_k
      always_ff @(posedge clk) begin
        rel4[k][c] <= rel3[k][c];
        e4[k][c]   <= e3[k][c];
        ae4[k][c]  <= e3[k][c][EW-1] ? -AEW'(e3[k][c]) : AEW'(e3[k][c]);
      end
    end
  end

  // ---------------- stages 5..8: multipliers ----------------
  // pe[k][v][c][d] = rel[v][c] * e[k][d]; pr[k][c][d] = size[c] * |e[k][d]|
  logic signed [RW+EW-1:0] pe [3][3][3][3];
  logic signed [32+AEW-1:0] pr [3][3][3];
  logic signed [RW+NW-1:0] pn [3][3];
  logic signed [32+ANW-1:0] rn [3];

  for (genvar c = 0; c < 3; c++) begin : g_mc
    tvo_mul #(.AW(32), .BW(ANW)) u_rn (
      .clk(clk), .a(sz[c]), .b(an4[c]), .p(rn[c])
    );
    for (genvar v = 0; v < 3; v++) begin : g_mn
      tvo_mul #(.AW(RW), .BW(NW)) u_pn (
        .clk(clk), .a(rel4[v][c]), .b(n4[c]), .p(pn[v][c])
      );
    end
    for (genvar d = 0; d < 3; d++) begin : g_md
      for (genvar k = 0; k < 3; k++) begin : g_mk
        if (c != d) begin : g_off
          tvo_mul #(.AW(32), .BW(AEW)) u_pr (
            .clk(clk), .a(sz[c]), .b(ae4[k][d]), .p(pr[k][c][d])
          );
          for (genvar v = 0; v < 3; v++) begin : g_mv
            tvo_mul #(.AW(RW), .BW(EW)) u_pe (
              .clk(clk), .a(rel4[v][c]), .b(e4[k][d]), .p(pe[k][v][c][d])
            );
          end
        end else begin : g_diag
          assign pr[k][c][d] = '0;
          for (genvar v = 0; v < 3; v++) begin : g_mv
            assign pe[k][v][c][d] = '0;
          end
        end
      end
    end
  end

  // ---------------- stage 9: projections and radii ----------------
  logic signed [EDW-1:0] sde [3][3][3];   // [edge][axis][vertex]
  logic signed [EDW-1:0] sre [3][3];
  logic signed [NDW-1:0] sdn [3];
  logic signed [NDW-1:0] srn;

  always_ff @(posedge clk) begin
    srn <= NDW'(rn[0]) + NDW'(rn[1]) + NDW'(rn[2]);
  end

  for (genvar v = 0; v < 3; v++) begin : g_sn
    always_ff @(posedge clk) begin
      sdn[v] <= NDW'(pn[v][0]) + NDW'(pn[v][1]) + NDW'(pn[v][2]);
    end
  end

  // axis j of edge k is edge x (box axis j); uses the other two components
  for (genvar k = 0; k < 3; k++) begin : g_se
    for (genvar j = 0; j < 3; j++) begin : g_j
      localparam int C1 = (j + 1) % 3;
      localparam int C2 = (j + 2) % 3;
      always_ff @(posedge clk) begin
        sre[k][j] <= EDW'(pr[k][C1][C2]) + EDW'(pr[k][C2][C1]);
      end
      for (genvar v = 0; v < 3; v++) begin : g_v
        always_ff @(posedge clk) begin
          sde[k][j][v] <= EDW'(pe[k][v][C1][C2]) - EDW'(pe[k][v][C2][C1]);
        end
      end
    end
  end

  // ---------------- stages 10..12: axis tests ----------------
  logic [8:0] sep_e;
  logic       sep_n;
  logic [2:0] sep_f, sep_f12;

  for (genvar k = 0; k < 3; k++) begin : g_ae
    for (genvar j = 0; j < 3; j++) begin : g_j
      tvo_axis #(.W(EDW)) u_ax (
        .clk(clk), .p0(sde[k][j][0]), .p1(sde[k][j][1]), .p2(sde[k][j][2]),
        .r(sre[k][j]), .tol(tol), .sep(sep_e[k*3+j])
      );
    end
  end

  tvo_axis #(.W(NDW)) u_axn (
    .clk(clk), .p0(sdn[0]), .p1(sdn[1]), .p2(sdn[2]),
    .r(srn), .tol(tol), .sep(sep_n)
  );

  // face axes run straight off stage 4, then wait for the rest
  for (genvar j = 0; j < 3; j++) begin : g_af
    tvo_axis #(.W(FW)) u_axf (
      .clk(clk), .p0(FW'(rel4[0][j])), .p1(FW'(rel4[1][j])), .p2(FW'(rel4[2][j])),
      .r(FW'(sz[j])), .tol(tol), .sep(sep_f[j])
    );
  end

  tvo_dly #(.W(3), .N(5)) u_fdly (.clk(clk), .d(sep_f), .q(sep_f12));

  // ---------------- result queue ----------------
  logic          qmem [QD];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   qcnt;
  logic           push;

  assign push = vl[PIPE-1];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wp] <= ~(|sep_e | sep_n | |sep_f12);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      qcnt <= '0;
    end else begin
      if (push)    wp <= wp + 1'b1;
      if (acc_out) rp <= rp + 1'b1;
      qcnt <= qcnt + (QAW+1)'(push) - (QAW+1)'(acc_out);
    end
  end

  assign out_valid = (qcnt != '0);
  assign overlaps  = qmem[rp];
endmodule
`default_nettype wire

@@ src/tvo_dly.sv @@
// Fixed-length delay line for side data.
// No dependencies.
`default_nettype none
module tvo_dly #(
  parameter int W = 1,
  parameter int N = 2
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);
  logic [W-1:0] taps [N];

  always_ff @(posedge clk) begin
    taps[0] <= d;
    for (int i = 1; i < N; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign q = taps[N-1];
endmodule
`default_nettype wire

@@ src/tvo_mul.sv @@
// Pipelined signed multiplier: B is split into NST chunks, one partial
// product accumulated per stage. No dependencies.
`default_nettype none
module tvo_mul #(
  parameter int AW  = 32,
  parameter int BW  = 32,
  parameter int NST = 4
) (
  input  wire logic                 clk,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0]   p
);
  localparam int CW = (BW + NST - 1) / NST;
  localparam int BX = CW * NST;
  localparam int PW = AW + BW;

  logic signed [BX-1:0] bx;
  logic signed [AW-1:0] a_q   [NST-1];
  logic signed [BX-1:0] b_q   [NST-1];
  logic signed [PW-1:0] acc_q [NST];

  assign bx = BX'(b);

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic signed [AW-1:0] a_i;
    logic signed [BX-1:0] b_i;
    logic signed [PW-1:0] acc_i;
    logic signed [CW:0]   ch;
    logic signed [AW+CW:0] t;

    if (s == 0) begin : g_first
      assign a_i   = a;
      assign b_i   = bx;
      assign acc_i = '0;
    end else begin : g_next
      assign a_i   = a_q[s-1];
      assign b_i   = b_q[s-1];
      assign acc_i = acc_q[s-1];
    end

    // top chunk carries the sign, the rest are unsigned digits
    if (s == NST - 1) begin : g_top
      assign ch = {b_i[BX-1], b_i[s*CW +: CW]};
    end else begin : g_low
      assign ch = {1'b0, b_i[s*CW +: CW]};
      always_ff @(posedge clk) begin
        a_q[s] <= a_i;
        b_q[s] <= b_i;
      end
    end

    assign t = a_i * ch;

    always_ff @(posedge clk) begin
      acc_q[s] <= acc_i + (PW'(t) <<< (s * CW));
    end
  end

  assign p = acc_q[NST-1];
endmodule
`default_nettype wire

@@ src/tvo_axis.sv @@
// Interval test on one axis: min/max of three projections, clamp to the
// box radius, compare against tolerance. Uses tvo_pkg.
`default_nettype none
module tvo_axis #(
  parameter int W = 46
) (
  input  wire logic                        clk,
  input  wire logic signed [W-1:0]         p0,
  input  wire logic signed [W-1:0]         p1,
  input  wire logic signed [W-1:0]         p2,
  input  wire logic signed [W-1:0]         r,
  input  wire logic [tvo_pkg::TOL_W-1:0]   tol,
  output logic                             sep
);
  import tvo_pkg::*;

  logic signed [W-1:0] m01, x01;
  logic signed [W-1:0] pmin, pmax, r1;
  logic signed [W-1:0] hi, lo;
  logic signed [W+1:0] diff;

  assign m01 = (p1 < p0) ? p1 : p0;
  assign x01 = (p0 < p1) ? p1 : p0;

  always_ff @(posedge clk) begin
    pmin <= (p2 < m01) ? p2 : m01;
    pmax <= (x01 < p2) ? p2 : x01;
    r1   <= r;
    hi   <= (pmax < r1) ? pmax : r1;
    lo   <= (pmin < -r1) ? -r1 : pmin;
    sep  <= diff[W+1];
  end

  // twice the tolerance, since projections are at double scale
  assign diff = (W+2)'(hi) - (W+2)'(lo) + $signed((W+2)'({tol, 1'b0}));
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking bench for triangle_voxel_overlap_test: a separating-axis overlap
// predictor in 128-bit arithmetic and a small scoreboard class.
// Depends on tvo_pkg and the block itself.
`default_nettype none
module testbench;
  import tvo_pkg::*;

  typedef logic signed [127:0] wide_t;

  // one triangle/voxel word as driven on the input ports
  typedef struct {
    logic signed [31:0] v [3][3];
    logic [9:0]         idx [3];
  } tri_word_t;

  // current register image, kept in step with every write
  logic signed [31:0] org_q [3];
  logic [30:0]        size_q [3];
  logic [15:0]        tol_q;

  // Axis test at twice scale: relative vertices are 2v - 2c, extent is full size.
  function automatic bit axis_splits(wide_t rel [3][3], wide_t sz [3], wide_t ax [3]);
    wide_t p, pmin, pmax, r, hi, lo;
    for (int k = 0; k < 3; k++) begin
      p = rel[k][0] * ax[0] + rel[k][1] * ax[1] + rel[k][2] * ax[2];
      if (k == 0 || p < pmin) pmin = p;
      if (k == 0 || p > pmax) pmax = p;
    end
    r = sz[0] * (ax[0] < 0 ? -ax[0] : ax[0]) + sz[1] * (ax[1] < 0 ? -ax[1] : ax[1])
      + sz[2] * (ax[2] < 0 ? -ax[2] : ax[2]);
    hi = pmax < r ? pmax : r;
    lo = pmin < -r ? -r : pmin;
    return (hi - lo + 2 * wide_t'(tol_q)) < 0;
  endfunction

  function automatic bit overlap_of(tri_word_t w);
    wide_t rel [3][3];
    wide_t sz [3];
    wide_t ed [3][3];
    wide_t ax [3];
    wide_t e1 [3];
    wide_t e2 [3];
    wide_t ctr;
    bit sep;
    sep = 0;
    for (int c = 0; c < 3; c++) begin
      ctr = 2 * wide_t'(org_q[c]) + (2 * wide_t'(w.idx[c]) + 1) * wide_t'(size_q[c]);
      sz[c] = wide_t'(size_q[c]);
      for (int k = 0; k < 3; k++) begin
        rel[k][c] = 2 * wide_t'(w.v[k][c]) - ctr;
        ed[k][c] = wide_t'(w.v[(k + 1) % 3][c]) - wide_t'(w.v[k][c]);
      end
      e1[c] = wide_t'(w.v[1][c]) - wide_t'(w.v[0][c]);
      e2[c] = wide_t'(w.v[2][c]) - wide_t'(w.v[0][c]);
    end
    // box faces
    for (int j = 0; j < 3; j++) begin
      for (int c = 0; c < 3; c++) ax[c] = (c == j);
      if (axis_splits(rel, sz, ax)) sep = 1;
    end
    // edge cross box axis
    for (int k = 0; k < 3; k++) begin
      ax[0] = 0;           ax[1] = ed[k][2];  ax[2] = -ed[k][1];
      if (axis_splits(rel, sz, ax)) sep = 1;
      ax[0] = -ed[k][2];   ax[1] = 0;         ax[2] = ed[k][0];
      if (axis_splits(rel, sz, ax)) sep = 1;
      ax[0] = ed[k][1];    ax[1] = -ed[k][0]; ax[2] = 0;
      if (axis_splits(rel, sz, ax)) sep = 1;
    end
    // triangle normal
    ax[0] = e1[1] * e2[2] - e1[2] * e2[1];
    ax[1] = e1[2] * e2[0] - e1[0] * e2[2];
    ax[2] = e1[0] * e2[1] - e1[1] * e2[0];
    if (axis_splits(rel, sz, ax)) sep = 1;
    return !sep;
  endfunction

  int errors = 0;

  task automatic report(string what);
    errors++;
    $display("mismatch @%0t: %s", $time, what);
  endtask

  class overlap_board;
    bit pending [$];
    int hits, checked;
    function void note_word(tri_word_t w);
      pending = {pending, overlap_of(w)};
    endfunction
    task check_word(bit got);
      bit want;
      if (pending.size() == 0) begin
        report($sformatf("overlaps=%0b with nothing pending", got));
        return;
      end
      want = pending.pop_front();
      checked++;
      hits += got;
      if (got !== want) report($sformatf("overlaps=%0b want %0b", got, want));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IW-1:0] cfg_index = REG_ORIGIN_X;
  logic [CFG_DW-1:0] cfg_data = 0;
  logic in_valid = 0, in_ready;
  logic signed [31:0] vax = 0, vay = 0, vaz = 0, vbx = 0, vby = 0, vbz = 0;
  logic signed [31:0] vcx = 0, vcy = 0, vcz = 0;
  logic [9:0] cix = 0, ciy = 0, ciz = 0;
  logic out_valid, out_ready = 0, overlaps;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  triangle_voxel_overlap_test dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .vertex_a_x(vax), .vertex_a_y(vay), .vertex_a_z(vaz),
    .vertex_b_x(vbx), .vertex_b_y(vby), .vertex_b_z(vbz),
    .vertex_c_x(vcx), .vertex_c_y(vcy), .vertex_c_z(vcz),
    .cell_ix(cix), .cell_iy(ciy), .cell_iz(ciz),
    .out_valid(out_valid), .out_ready(out_ready), .overlaps(overlaps)
  );

  overlap_board board = new();

  // knobs shared by the sender and receiver processes
  bit idle_on = 1;      // random gaps enabled
  bit hold_rx = 0;      // receiver long hold-off request
  int words_in = 0, cfg_writes = 0;
  int quiet = 0;
  localparam int QUIET_LIMIT = 20000;

  // Receiver: ~32% stalls when idling is on; a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) board.check_word(overlaps);
      out_ready <= !hold_rx && (!idle_on || $urandom_range(99) >= 32);
    end
  end

  // Watchdog: counts cycles with no accepted word on any channel while work is pending or offered.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || rst || board.pending.size() == 0 && !in_valid && !cfg_valid)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog expired with %0d pending", board.pending.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays up across a run of writes; the caller drops it at the end
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ORIGIN_X: org_q[0] = val;
      REG_ORIGIN_Y: org_q[1] = val;
      REG_ORIGIN_Z: org_q[2] = val;
      REG_SIZE_X:   size_q[0] = val[30:0];
      REG_SIZE_Y:   size_q[1] = val[30:0];
      REG_SIZE_Z:   size_q[2] = val[30:0];
      REG_TOL:      tol_q = val[15:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Wait until every expected word is back, plus a latency margin.
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_word(tri_word_t w);
    while (idle_on && $urandom_range(99) < 32) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {vax, vay, vaz} <= {w.v[0][0], w.v[0][1], w.v[0][2]};
    {vbx, vby, vbz} <= {w.v[1][0], w.v[1][1], w.v[1][2]};
    {vcx, vcy, vcz} <= {w.v[2][0], w.v[2][1], w.v[2][2]};
    {cix, ciy, ciz} <= {w.idx[0], w.idx[1], w.idx[2]};
    do @(posedge clk); while (!in_ready);
    board.note_word(w);
    words_in++;
  endtask

  // Small vertex near the current box, in cell units, so overlaps are frequent.
  function automatic logic signed [31:0] near_coord(int c, logic [9:0] idx);
    longint base;
    base = longint'(org_q[c]) + longint'(idx) * longint'(size_q[c]);
    base = base + ($signed($urandom_range(600)) - 250) * longint'(size_q[c]) / 100;
    return base[31:0];
  endfunction

  function automatic tri_word_t rand_word(bit wide_mode);
    tri_word_t w;
    for (int c = 0; c < 3; c++) begin
      w.idx[c] = wide_mode ? 10'($urandom) : 10'($urandom_range(7));
      for (int k = 0; k < 3; k++)
        w.v[k][c] = wide_mode ? $urandom : near_coord(c, w.idx[c]);
    end
    // sometimes collapse a vertex to get degenerate triangles
    if ($urandom_range(19) == 0) w.v[2] = w.v[$urandom_range(1)];
    return w;
  endfunction

  task automatic set_grid(logic [31:0] ox, oy, oz, sx, sy, sz, tl);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_TOL, tl);
    cfg_valid <= 0;
  endtask

  initial begin
    tri_word_t w;
    org_q = '{0, 0, 0};
    size_q = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
    tol_q = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset grid, field extremes, degenerate and touching cases.
    for (int n = 0; n < 20; n++) begin
      for (int c = 0; c < 3; c++) begin
        w.idx[c] = (n % 4 == 0) ? 10'h3ff : (n % 4 == 1) ? 10'h0 : 10'(n);
        for (int k = 0; k < 3; k++)
          case (n % 5)
            0: w.v[k][c] = 32'sh7fffffff;
            1: w.v[k][c] = 32'sh80000000;
            2: w.v[k][c] = (k == c) ? 32'sh80000000 : 32'sh7fffffff;
            3: w.v[k][c] = 32'sh10000 * (w.idx[c] + k % 2); // edge on box face
            default: w.v[k][c] = 0;                          // point triangle
          endcase
      end
      send_word(w);
    end
    in_valid <= 0;
    drain();

    // Phases over several grid settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_grid(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0);
        1: set_grid(32'h80000000, 32'h7fffffff, 32'hffff0000, 1, 1, 1, 16'hffff);
        2: set_grid(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h7fffffff,
                    32'h7fffffff, 0);
        3: set_grid($urandom, $urandom, $urandom, $urandom_range(32'h40000, 32'h400),
                    $urandom_range(32'h40000, 32'h400), $urandom_range(32'h40000, 32'h400),
                    $urandom_range(16'hffff));
        4: set_grid(32'hfff00000, 32'h00100000, 32'h12345678, 32'h8000, 32'h20000,
                    32'h10000, 16'h8000);
        5: set_grid($urandom, $urandom, $urandom, $urandom_range(32'h7fffffff, 1),
                    $urandom_range(32'h7fffffff, 1), $urandom_range(32'h7fffffff, 1),
                    $urandom_range(16'hffff));
        6: set_grid(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 16'h1);
        default: set_grid(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 32'h2aaaaaaa,
                          32'h55555555, 32'h1, 16'h5555);
      endcase
      idle_on = (ph != 2);  // one phase runs with no gaps at all
      if (ph == 4) begin
        // long receiver hold-off while the sender keeps offering words
        fork
          begin
            hold_rx = 1;
            repeat (300) @(posedge clk);
            hold_rx = 0;
          end
        join_none
      end
      for (int n = 0; n < 225; n++) begin
        send_word(rand_word($urandom_range(99) < 15));
        if (n == 100) begin
          // sender pause until all outstanding results are back
          in_valid <= 0;
          drain();
        end
      end
      in_valid <= 0;
      drain();
    end
    idle_on = 1;

    $display("covered %0d triangle words, %0d register writes, %0d overlaps of %0d checked",
             words_in, cfg_writes, board.hits, board.checked);
    if (errors == 0 && board.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
